@@ hw/rtl/sensor_frame_checksum_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the decoder top-level RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECKSUM_DECODER_ASSERT_SVH
`define SENSOR_FRAME_CHECKSUM_DECODER_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SFCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfcd assertion failed");

// next-cycle implication
`define SFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfcd assertion failed");

`endif

@@ hw/rtl/sfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types and constants of the sensor frame checksum decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

	localparam int unsigned COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [7:0] HDR_BYTE = 8'h25;
	localparam logic [7:0] BAT_MASK = 8'h08;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_LENGTH = 2'd1,
		ST_HEADER = 2'd2,
		ST_SUM    = 2'd3
	} sfcd_status_t;

	typedef struct packed {
		sfcd_status_t       status;
		logic               frame_valid;
		logic [7:0]         sensor_id;
		logic               battery_low;
		logic signed [15:0] temperature_tenths;
		logic [7:0]         humidity;
		logic [15:0]        pressure_tenths;
		logic [7:0]         received_checksum;
	} sfcd_result_t;

endpackage

@@ hw/rtl/sfcd_frame.sv @@
// ----------------------------------------------------------------------------
// sfcd_frame
// Per-frame state: byte count, running sum and captured fields, plus the
// end-of-frame checks that form the result for the final byte.
// ----------------------------------------------------------------------------
module sfcd_frame #(
	parameter int unsigned FRAME_LEN = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output sfcd_pkg::sfcd_result_t result
);
	import sfcd_pkg::*;

	localparam logic [COUNT_W-1:0] POS_HEADER = 5'd0;
	localparam logic [COUNT_W-1:0] POS_ID     = 5'd1;
	localparam logic [COUNT_W-1:0] POS_FLAGS  = 5'd2;
	localparam logic [COUNT_W-1:0] POS_TEMP_H = 5'd3;
	localparam logic [COUNT_W-1:0] POS_TEMP_L = 5'd4;
	localparam logic [COUNT_W-1:0] POS_HUM    = 5'd5;
	localparam logic [COUNT_W-1:0] POS_PRES_H = 5'd6;
	localparam logic [COUNT_W-1:0] POS_PRES_L = 5'd7;
	localparam logic [COUNT_W-1:0] LEN        = COUNT_W'(FRAME_LEN);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic [7:0]         sum_q;
	logic               header_ok_q;
	logic [7:0]         id_q;
	logic               battery_q;
	logic [15:0]        temp_q;
	logic [7:0]         hum_q;
	logic [15:0]        pres_q;
	sfcd_status_t       status;

	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);

	always_comb begin
		if (count_next != LEN) begin
			status = ST_LENGTH;
		end else if (!header_ok_q) begin
			status = ST_HEADER;
		end else if (sum_q != data_byte) begin
			status = ST_SUM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		result = '0;
		result.status = status;
		result.frame_valid = (status == ST_OK);
		if (status == ST_OK) begin
			result.sensor_id = id_q;
			result.battery_low = battery_q;
			result.temperature_tenths = temp_q;
			result.humidity = hum_q;
			result.pressure_tenths = pres_q;
		end
		if (status == ST_OK || status == ST_SUM) begin
			result.received_checksum = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			header_ok_q <= 1'b0;
			id_q <= '0;
			battery_q <= 1'b0;
			temp_q <= '0;
			hum_q <= '0;
			pres_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				count_q <= '0;
				sum_q <= '0;
				header_ok_q <= 1'b0;
				id_q <= '0;
				battery_q <= 1'b0;
				temp_q <= '0;
				hum_q <= '0;
				pres_q <= '0;
			end else begin
				count_q <= count_next;
				sum_q <= sum_q + data_byte;
				case (count_q)
					POS_HEADER: header_ok_q <= (data_byte == HDR_BYTE);
					POS_ID:     id_q <= data_byte;
					POS_FLAGS:  battery_q <= |(data_byte & BAT_MASK);
					POS_TEMP_H: temp_q[15:8] <= data_byte;
					POS_TEMP_L: temp_q[7:0] <= data_byte;
					POS_HUM:    hum_q <= data_byte;
					POS_PRES_H: pres_q[15:8] <= data_byte;
					POS_PRES_L: pres_q[7:0] <= data_byte;
					default:    ;
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/sensor_frame_checksum_decoder.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_checksum_decoder
// Decodes weather-sensor radio frames byte by byte and checks length,
// header and checksum, giving one result item per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on the slave side while s_tready is high, tlast on the final byte.
// Every byte passes an input register and is folded into the frame state as
// it leaves that register; the final byte loads the result register at that
// same edge, so a result item is offered on the master side once its final
// byte has left the input register. s_tready drops only
// while a final byte sits in the input register and the previous result has
// not been taken. Result fields other than status, frame_valid and the
// checksum read zero for a rejected frame; received_checksum also reads zero
// for length and header errors.
module sensor_frame_checksum_decoder #(
	parameter int unsigned FRAME_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] sensor_id, [8] battery_low,
	                               // [24:9] temperature_tenths, [32:25] humidity,
	                               // [48:33] pressure_tenths,
	                               // [56:49] received_checksum, [63:57] zero
	output logic [2:0]  m_tuser    // [1:0] status, [2] frame_valid
);
	import sfcd_pkg::*;

	`include "sensor_frame_checksum_decoder_assert.svh"

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         advance;
	logic         out_valid_q;
	sfcd_result_t out_q;
	sfcd_result_t result;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	sfcd_frame #(
		.FRAME_LEN(FRAME_LEN)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.received_checksum, out_q.pressure_tenths, out_q.humidity,
		out_q.temperature_tenths, out_q.battery_low, out_q.sensor_id};
	assign m_tuser  = {out_q.frame_valid, out_q.status};

	`SFCD_ASSERT_NOW(a_mid_byte_flows, clk, arst_n, valid_s1 && !last_s1, advance && s_tready)
	`SFCD_ASSERT_NOW(a_valid_matches_status, clk, arst_n, out_valid_q,
		out_q.frame_valid == (out_q.status == ST_OK))
	`SFCD_ASSERT_NOW(a_rejected_fields_zero, clk, arst_n, out_valid_q && !out_q.frame_valid,
		out_q.sensor_id == 8'd0 && out_q.temperature_tenths == 16'sd0 &&
		out_q.pressure_tenths == 16'd0)
	`SFCD_ASSERT_NOW(a_checksum_zero_on_frame_error, clk, arst_n,
		out_valid_q && (out_q.status == ST_LENGTH || out_q.status == ST_HEADER),
		out_q.received_checksum == 8'd0)
	`SFCD_ASSERT_NEXT(a_final_byte_gives_result, clk, arst_n, advance && last_s1, out_valid_q)

endmodule
